### hw/rtl/pac_pkg.sv
// Shared definitions for the pixel alpha compositor: blend mode codes and
// ARGB8888 channel layout constants. No dependencies.
`default_nettype none

package pac_pkg;

	typedef logic [2:0] mode_t;

	localparam mode_t MODE_COPY     = 3'd0;
	localparam mode_t MODE_SRC_OVER = 3'd1;
	localparam mode_t MODE_DST_OVER = 3'd2;
	localparam mode_t MODE_SRC_IN   = 3'd3;
	localparam mode_t MODE_DST_IN   = 3'd4;
	localparam mode_t MODE_SCREEN   = 3'd5;

	localparam int unsigned PIXEL_W  = 32;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned NUM_CHAN = 4;
	localparam int unsigned ALPHA_LSB = 24;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [CHAN_W-1:0]  chan_t;

endpackage

`default_nettype wire

### hw/rtl/pac_blend.sv
// Combinational compositing datapath: one source and one destination pixel
// in, the new destination pixel out. Depends on pac_pkg.
`default_nettype none

module pac_blend
	import pac_pkg::*;
(
	input  wire mode_t  mode,
	input  wire pixel_t src,
	input  wire pixel_t dst,
	input  wire logic   covers,
	output pixel_t      res
);

	chan_t  sa;
	chan_t  da;
	chan_t  inv_sa;
	pixel_t over_pix;
	pixel_t in_pix;
	logic   sa_zero;
	logic   sa_full;
	logic   da_zero;

	assign sa      = src[ALPHA_LSB +: CHAN_W];
	assign da      = dst[ALPHA_LSB +: CHAN_W];
	assign inv_sa  = CHAN_MAX - sa;
	assign sa_zero = (sa == '0);
	assign sa_full = (sa == CHAN_MAX);
	assign da_zero = (da == '0);

	// Per-channel blends. The alpha channel of the source already holds Sa,
	// so the same formula serves all four lanes.
	always_comb begin
		logic [2*CHAN_W-1:0] mix;
		logic [2*CHAN_W-1:0] scl;
		for (int i = 0; i < NUM_CHAN; i++) begin
			mix = dst[i*CHAN_W +: CHAN_W] * inv_sa + src[i*CHAN_W +: CHAN_W] * sa;
			scl = src[i*CHAN_W +: CHAN_W] * da;
			over_pix[i*CHAN_W +: CHAN_W] = mix[2*CHAN_W-1:CHAN_W];
			in_pix[i*CHAN_W +: CHAN_W]   = scl[2*CHAN_W-1:CHAN_W];
		end
	end

	always_comb begin
		res = dst;
		unique case (mode)
			MODE_COPY: begin
				if (covers)
					res = src;
			end
			MODE_SRC_OVER, MODE_SCREEN: begin
				if (covers) begin
					if (sa_full)
						res = src;
					else if (!sa_zero)
						res = over_pix;
				end
			end
			MODE_DST_OVER: begin
				if (covers && da_zero && !sa_zero)
					res = src;
			end
			MODE_SRC_IN: begin
				res = (covers && !da_zero && !sa_zero) ? in_pix : '0;
			end
			MODE_DST_IN: begin
				if (!(covers && !da_zero && !sa_zero))
					res = '0;
			end
			default: begin
				res = dst;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/pixel_alpha_compositor_core.sv
// Top level of the pixel alpha compositor: input register, blend datapath
// and result register. Depends on pac_pkg and pac_blend.
`default_nettype none

// Usage:
// A pixel transfer is issued by raising start with src_pixel, dst_pixel and
// src_covers valid; it is taken at any rising edge where start is high and
// busy is low. busy is never raised, so one pixel may be issued on every
// clock cycle with no gaps.
// The pixel is captured in an input register, blended by a short
// combinational path (8x8 multiplies, one add and a mode select per
// channel), and captured in a result register. The new destination pixel
// appears on result_pixel once it is in the result register, with
// result_valid high for exactly one cycle. Throughput is one pixel per clock.
// The receiver cannot stall the block; it must take each result in the
// cycle in which result_valid is high.
// The blend mode register is written over the cfg_valid/cfg_ready channel
// (cfg_ready is always high). It should only be changed while no pixel is
// in flight, since a pixel in the input register is blended under the new mode at once.
// Reset (arst_n low) clears the mode to copy and drops all in-flight
// pixels; no result strobe is produced for them.

module pixel_alpha_compositor_core
	import pac_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	output logic        busy,
	input  wire pixel_t src_pixel,
	input  wire pixel_t dst_pixel,
	input  wire logic   src_covers,
	output logic        result_valid,
	output pixel_t      result_pixel,
	input  wire logic   cfg_valid,
	output logic        cfg_ready,
	input  wire mode_t  cfg_data
);

	mode_t  mode_q;
	logic   vld_s1;
	pixel_t src_s1;
	pixel_t dst_s1;
	logic   cov_s1;
	pixel_t blend_res;
	logic   vld_s2;
	pixel_t res_s2;

	// The block never holds off a new pixel or a mode write.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COPY;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			src_s1 <= src_pixel;
			dst_s1 <= dst_pixel;
			cov_s1 <= src_covers;
		end
	end

	pac_blend u_blend (
		.mode   (mode_q),
		.src    (src_s1),
		.dst    (dst_s1),
		.covers (cov_s1),
		.res    (blend_res)
	);

	// Result register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2 <= blend_res;
		end
	end

	assign result_valid = vld_s2;
	assign result_pixel = res_s2;

endmodule

`default_nettype wire

### test/pixel_alpha_compositor_core_tb.sv
// Self-checking testbench for pixel_alpha_compositor_core: drives pixel transfers
// under every blend mode and checks each result against a built-in blend predictor.
// Depends on pac_pkg and the compositor RTL.
`timescale 1ns / 1ps

module pixel_alpha_compositor_core_tb
	import pac_pkg::*;
();

	localparam int CLK_PERIOD   = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_PHASES  = 13;
	localparam int PHASE_PIXELS = 112;
	localparam int QUIET_PHASE  = 2;
	localparam int DRAIN_CYCLES = 8;

	// Scoreboard: keeps its own copy of the blend mode, predicts the new
	// destination pixel for every accepted transfer and compares results in order.
	class blend_scoreboard;
		mode_t  cur_mode = MODE_COPY;
		pixel_t expected_pixels[$];
		int     errors = 0;
		int     pixels_noted = 0;
		int     results_checked = 0;

		function chan_t over_mix(chan_t d, chan_t s, chan_t sa);
			logic [15:0] acc;
			acc = d * (CHAN_MAX - sa) + s * sa;
			return acc[15:8];
		endfunction

		function pixel_t blend_pixel(pixel_t s, pixel_t d, logic cov);
			chan_t       sa;
			chan_t       da;
			pixel_t      r;
			logic [15:0] prod;
			sa = s[ALPHA_LSB +: CHAN_W];
			da = d[ALPHA_LSB +: CHAN_W];
			r  = d;
			case (cur_mode)
				MODE_COPY: begin
					if (cov)
						r = s;
				end
				MODE_SRC_OVER, MODE_SCREEN: begin
					if (cov) begin
						if (sa == CHAN_MAX)
							r = s;
						else if (sa != 0)
							for (int i = 0; i < NUM_CHAN; i++)
								r[i*CHAN_W +: CHAN_W] = over_mix(d[i*CHAN_W +: CHAN_W],
									s[i*CHAN_W +: CHAN_W], sa);
					end
				end
				MODE_DST_OVER: begin
					if (cov && da == 0 && sa != 0)
						r = s;
				end
				MODE_SRC_IN: begin
					r = '0;
					if (cov && da != 0 && sa != 0)
						for (int i = 0; i < NUM_CHAN; i++) begin
							prod = s[i*CHAN_W +: CHAN_W] * da;
							r[i*CHAN_W +: CHAN_W] = prod[15:8];
						end
				end
				MODE_DST_IN: begin
					if (!(cov && da != 0 && sa != 0))
						r = '0;
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void note_pixel(pixel_t s, pixel_t d, logic cov);
			expected_pixels.push_back(blend_pixel(s, d, cov));
			pixels_noted++;
		endfunction

		function void check_result(pixel_t actual);
			pixel_t exp_px;
			results_checked++;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result_pixel %08h with nothing pending",
					$time, actual);
				errors++;
				return;
			end
			exp_px = expected_pixels.pop_front();
			if (exp_px !== actual) begin
				$display("%0t: result_pixel mismatch, expected %08h actual %08h",
					$time, exp_px, actual);
				errors++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	pixel_t src_pixel;
	pixel_t dst_pixel;
	logic   src_covers;
	logic   result_valid;
	pixel_t result_pixel;
	logic   cfg_valid;
	logic   cfg_ready;
	mode_t  cfg_data;

	blend_scoreboard sb;
	int cycles = 0;
	int mode_writes = 0;

	pixel_alpha_compositor_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.src_pixel    (src_pixel),
		.dst_pixel    (dst_pixel),
		.src_covers   (src_covers),
		.result_valid (result_valid),
		.result_pixel (result_pixel),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog. The slowest correct run stays well under this limit,
	// so reaching it means the block stopped producing results.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results pending",
				cycles, sb.pending());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Monitor. Inputs and outputs are both updated by nonblocking assignments
	// at the edge, so everything read here is the value that was present while
	// the edge happened. The result is checked before the new transfer is noted:
	// with the input and result registers in between, a transfer accepted at this
	// edge can never be the one whose result is arriving now.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(result_pixel);
			if (start && !busy)
				sb.note_pixel(src_pixel, dst_pixel, src_covers);
		end
	end

	// Random source or destination pixel. The alpha byte is steered toward the
	// values that select special paths (zero, opaque and their neighbors); the
	// color bytes are fully random so every bit toggles.
	function pixel_t rand_pixel();
		chan_t a;
		case ($urandom_range(7))
			0: a = '0;
			1: a = CHAN_MAX;
			2: a = 8'h01;
			3: a = 8'hFE;
			default: a = chan_t'($urandom);
		endcase
		return {a, 24'($urandom)};
	endfunction

	// Presents one pixel and holds it until the block takes it. The caller is
	// always at a rising edge, so start is raised once here and only lowered by
	// an idle gap, a mode write or the end of the run.
	task send_pixel(input pixel_t s, input pixel_t d, input logic cov);
		start      <= 1'b1;
		src_pixel  <= s;
		dst_pixel  <= d;
		src_covers <= cov;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Random sender gap, skipped entirely in the quiet phase.
	// Gaps are rare: one is taken before about three pixels in a hundred.
	task sender_gap(input bit quiet);
		if (!quiet && $urandom_range(99) < 3) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	// Changes the blend mode only once the pipeline is empty. Every pixel yields
	// a result, so an empty expectation queue means nothing is in flight; an
	// extra wait is still made anyway before the write transfer.
	task write_mode(input mode_t m);
		start <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.cur_mode = m;
		mode_writes++;
	endtask

	// Directed pixels (first two only with all_cases): opaque source over a cleared
	// destination, a transparent source over an opaque destination, half-transparent
	// source over a half-transparent destination, and a source not covering the spot.
	task directed_pixels(input bit all_cases);
		if (all_cases) begin
			send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
			send_pixel(32'h00FF_FFFF, 32'hFFFF_FFFF, 1'b1);
		end
		send_pixel(32'h80FF_00FF, 32'h7F00_FF00, 1'b1);
		send_pixel(32'hFF12_3456, 32'h01AB_CDEF, 1'b0);
	endtask

	initial begin
		mode_t phase_mode;

		sb         = new;
		arst_n     = 1'b0;
		start      = 1'b0;
		src_pixel  = '0;
		dst_pixel  = '0;
		src_covers = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = MODE_COPY;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first few pixels run under the reset mode, which must be copy.
		directed_pixels(1'b1);

		// Directed pass over the remaining modes, including the two unused codes, which
		// must leave the destination unchanged.
		for (int m = MODE_SRC_OVER; m <= 7; m++) begin
			write_mode(mode_t'(m));
			directed_pixels(m <= MODE_SCREEN);
		end

		// Random phases. The first ones walk through the defined modes, starting
		// with both extremes; later ones pick modes at random, now and then an
		// unused code. One phase runs back to back with no sender gaps.
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: phase_mode = MODE_COPY;
				1: phase_mode = MODE_SCREEN;
				2: phase_mode = MODE_SRC_OVER;
				3: phase_mode = MODE_DST_OVER;
				4: phase_mode = MODE_SRC_IN;
				5: phase_mode = MODE_DST_IN;
				default: begin
					if ($urandom_range(9) == 0)
						phase_mode = mode_t'($urandom_range(6, 7));
					else
						phase_mode = mode_t'($urandom_range(MODE_COPY, MODE_SCREEN));
				end
			endcase
			write_mode(phase_mode);
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				sender_gap(p == QUIET_PHASE);
				send_pixel(rand_pixel(), rand_pixel(), $urandom_range(99) < 85);
			end
		end

		start <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d pixels under %0d mode writes; %0d results compared.",
			sb.pixels_noted, mode_writes, sb.results_checked);
		$display("Modes copy through screen plus unused codes, covered and uncovered.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/pac_pkg.sv
hw/rtl/pac_blend.sv
hw/rtl/pixel_alpha_compositor_core.sv
test/pixel_alpha_compositor_core_tb.sv
